@@ rtl/raid_stripe_address_map_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the RAID stripe address map unit.
// ---------------------------------------------------------------------------
`ifndef RAID_STRIPE_ADDRESS_MAP_UNIT_ASSERT_SVH
`define RAID_STRIPE_ADDRESS_MAP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define RSAM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define RSAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RSAM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RSAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/rsam_pkg.sv @@
// ---------------------------------------------------------------------------
// rsam_pkg
// Shared widths, register indexes and helpers of the stripe address map.
// ---------------------------------------------------------------------------
package rsam_pkg;

   localparam int ADDR_W    = 48;   // block address width
   localparam int DIV_W     = 26;   // widest divisor
   localparam int CHUNK_W   = 21;
   localparam int DISKS_W   = 6;
   localparam int RED_W     = 5;
   localparam int MAX_DISKS = 32;
   localparam int HALF_W    = ADDR_W / 2;

   localparam logic LBA = 1'b0;     // logical address kind

   typedef enum logic [2:0] {
      CSR_CHUNK_BLOCKS     = 3'd0,
      CSR_DISK_COUNT       = 3'd1,
      CSR_REDUNDANT_DISKS  = 3'd2,
      CSR_PHYS_STRIPE      = 3'd3,
      CSR_LOG_STRIPE       = 3'd4
   } csr_index_type;

   // A zero size register is used as one.
   function automatic logic [DIV_W-1:0] at_least_one(input logic [DIV_W-1:0] v);
      at_least_one = (v == '0) ? DIV_W'(1) : v;
   endfunction

endpackage

@@ rtl/rsam_div.sv @@
// ---------------------------------------------------------------------------
// rsam_div
// Pipelined restoring divider: one quotient bit per register stage.
// ---------------------------------------------------------------------------
module rsam_div
   import rsam_pkg::*;
(
   input  logic              clock,
   input  logic              advance,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic [ADDR_W-1:0] quotient,
   output logic [DIV_W-1:0]  remainder
);

   logic [ADDR_W-1:0] num_ff [ADDR_W];
   logic [DIV_W-1:0]  rem_ff [ADDR_W];
   logic [DIV_W-1:0]  den_ff [ADDR_W];

   for (genvar k = 0; k < ADDR_W; k++) begin : g_stage
      logic [ADDR_W-1:0] num_src;
      logic [DIV_W-1:0]  rem_src;
      logic [DIV_W-1:0]  den_src;
      logic [DIV_W:0]    trial;
      logic [DIV_W:0]    diff;
      logic              fits;

      if (k == 0) begin : g_first
         assign num_src = dividend;
         assign rem_src = '0;
         assign den_src = divisor;
      end else begin : g_next
         assign num_src = num_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      assign trial = {rem_src, num_src[ADDR_W-1]};
      assign diff  = trial - {1'b0, den_src};
      assign fits  = (trial >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[k] <= {num_src[ADDR_W-2:0], fits};
            rem_ff[k] <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            den_ff[k] <= den_src;
         end
      end
   end

   assign quotient  = num_ff[ADDR_W-1];
   assign remainder = rem_ff[ADDR_W-1];

endmodule

@@ rtl/raid_stripe_address_map_unit.sv @@
// ---------------------------------------------------------------------------
// raid_stripe_address_map_unit
// Block address translation for a striped disk array.
// ---------------------------------------------------------------------------
// One item enters and one result leaves per cycle unless a shown result is
// stalled. After the input stage, each item passes two chained 48-stage
// bit-serial divider pipelines with the middle stage between them: the first
// divides the start address by the stripe, chunk and physical stripe sizes
// (and the end address by the stripe size) in parallel, the second takes the
// chunk index modulo the member disk count. The whole pipeline moves as one;
// it holds only while a result is shown and stalled, and bubbles do not block
// input. Configuration registers are read live, so they are to be written
// only while no item is in flight; the block itself does not enforce this.
`include "raid_stripe_address_map_unit_assert.svh"

module raid_stripe_address_map_unit
   import rsam_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [DIV_W-1:0]  csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_block_address,
   input  logic [ADDR_W-1:0] req_end_address,
   input  logic              req_address_kind,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_stripe_index,
   output logic [24:0]       rsp_stripe_offset,
   output logic [ADDR_W-1:0] rsp_chunk_index,
   output logic [19:0]       rsp_chunk_offset,
   output logic [4:0]        rsp_disk_index,
   output logic [ADDR_W-1:0] rsp_disk_offset,
   output logic [ADDR_W:0]   rsp_stripe_span,
   output logic              rsp_range_error
);

   // Side data that rides along the first divider pipeline.
   typedef struct packed {
      logic kind;
      logic bad_order;
   } front_type;

   // Result fields that ride along the modulo pipeline.
   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] stripe_num;
      logic [24:0]       stripe_off;
      logic [ADDR_W-1:0] chunk_idx;
      logic [19:0]       chunk_off;
      logic [ADDR_W-1:0] disk_off;
      logic [ADDR_W:0]   span;
      logic              err;
   } back_type;

   // Configuration registers.
   logic [CHUNK_W-1:0] chunk_blocks_ff;
   logic [DISKS_W-1:0] disk_count_ff;
   logic [RED_W-1:0]   red_count_ff;
   logic [DIV_W-1:0]   pstripe_ff;
   logic [DIV_W-1:0]   lstripe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_blocks_ff <= CHUNK_W'(16);
         disk_count_ff   <= DISKS_W'(4);
         red_count_ff    <= RED_W'(1);
         pstripe_ff      <= DIV_W'(64);
         lstripe_ff      <= DIV_W'(48);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CHUNK_BLOCKS:    chunk_blocks_ff <= csr_data[CHUNK_W-1:0];
            CSR_DISK_COUNT:      disk_count_ff   <= csr_data[DISKS_W-1:0];
            CSR_REDUNDANT_DISKS: red_count_ff    <= csr_data[RED_W-1:0];
            CSR_PHYS_STRIPE:     pstripe_ff      <= csr_data;
            CSR_LOG_STRIPE:      lstripe_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Derived sizes. A disk count above the supported maximum is clamped, and
   // the clamped count is the one checked against the redundancy count.
   logic [DIV_W-1:0]   chunk_d;
   logic [DIV_W-1:0]   pstripe_d;
   logic [DIV_W-1:0]   lstripe_d;
   logic [DISKS_W-1:0] disks_c;
   logic               bad_red;

   assign chunk_d   = at_least_one(DIV_W'(chunk_blocks_ff));
   assign pstripe_d = at_least_one(pstripe_ff);
   assign lstripe_d = at_least_one(lstripe_ff);
   assign disks_c   = (disk_count_ff > DISKS_W'(MAX_DISKS)) ? DISKS_W'(MAX_DISKS)
                                                            : disk_count_ff;
   assign bad_red   = ({1'b0, red_count_ff} >= disks_c);

   // Member disks that a chunk index rotates over, for a given kind.
   function automatic logic [DIV_W-1:0] members_of(input logic kind,
                                                   input logic [DISKS_W-1:0] disks,
                                                   input logic [RED_W-1:0] red);
      logic [DISKS_W-1:0] m;
      m = (kind == LBA) ? disks - DISKS_W'(red) : disks;
      members_of = at_least_one(DIV_W'(m));
   endfunction

   // The whole pipeline advances unless a shown result is being held.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Input stage.
   logic              v0_ff;
   logic [ADDR_W-1:0] start0_ff;
   logic [ADDR_W-1:0] end0_ff;
   logic              kind0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start0_ff <= req_block_address;
         end0_ff   <= req_end_address;
         kind0_ff  <= req_address_kind;
      end
   end

   logic [DIV_W-1:0] stripe0;
   assign stripe0 = (kind0_ff == LBA) ? lstripe_d : pstripe_d;

   // First divider bank.
   logic [ADDR_W-1:0] sq, eq, cq, pq;
   logic [DIV_W-1:0]  sr, er, cr, pr;

   rsam_div u_div_stripe (.clock, .advance, .dividend(start0_ff), .divisor(stripe0),
                          .quotient(sq), .remainder(sr));
   rsam_div u_div_end    (.clock, .advance, .dividend(end0_ff), .divisor(stripe0),
                          .quotient(eq), .remainder(er));
   rsam_div u_div_chunk  (.clock, .advance, .dividend(start0_ff), .divisor(chunk_d),
                          .quotient(cq), .remainder(cr));
   rsam_div u_div_pstripe(.clock, .advance, .dividend(start0_ff), .divisor(pstripe_d),
                          .quotient(pq), .remainder(pr));

   logic      front_v_ff [ADDR_W];
   front_type front_ff   [ADDR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ADDR_W; k++) front_v_ff[k] <= 1'b0;
      end else if (advance) begin
         front_v_ff[0] <= v0_ff;
         for (int k = 1; k < ADDR_W; k++) front_v_ff[k] <= front_v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff[0] <= '{kind: kind0_ff, bad_order: (end0_ff < start0_ff)};
         for (int k = 1; k < ADDR_W; k++) front_ff[k] <= front_ff[k-1];
      end
   end

   // Stripe size that the item at the end of the first bank was divided by.
   logic [DIV_W-1:0] stripe_last;
   assign stripe_last = (front_ff[ADDR_W-1].kind == LBA) ? lstripe_d : pstripe_d;

   // Middle stage: disk offset partial products and stripe span.
   logic                m1_v_ff;
   logic                m1_kind_ff;
   logic [ADDR_W-1:0]   m1_sq_ff;
   logic [24:0]         m1_soff_ff;
   logic [ADDR_W-1:0]   m1_cq_ff;
   logic [CHUNK_W-1:0]  m1_crem_ff;
   logic [HALF_W+CHUNK_W-1:0] m1_plo_ff;
   logic [HALF_W+CHUNK_W-1:0] m1_phi_ff;
   logic [ADDR_W:0]     m1_span_ff;
   logic                m1_err_ff;

   logic [CHUNK_W-1:0] chunk_n;
   logic               err_mid;
   assign chunk_n = chunk_d[CHUNK_W-1:0];
   assign err_mid = front_ff[ADDR_W-1].bad_order || bad_red;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (advance) begin
         m1_v_ff <= front_v_ff[ADDR_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_kind_ff <= front_ff[ADDR_W-1].kind;
         m1_sq_ff   <= sq;
         m1_soff_ff <= sr[24:0];
         m1_cq_ff   <= cq;
         m1_crem_ff <= cr[CHUNK_W-1:0];
         m1_plo_ff  <= pq[HALF_W-1:0] * chunk_n;
         m1_phi_ff  <= pq[ADDR_W-1:HALF_W] * chunk_n;
         m1_span_ff <= err_mid ? '0 : ({1'b0, eq} - {1'b0, sq} + (ADDR_W+1)'(1));
         m1_err_ff  <= err_mid;
      end
   end

   logic [ADDR_W-1:0] disk_off_mid;
   assign disk_off_mid = ADDR_W'(m1_plo_ff) + {m1_phi_ff[HALF_W-1:0], HALF_W'(0)}
                         + ADDR_W'(m1_crem_ff);

   // Second divider: chunk index modulo the member disks.
   logic [ADDR_W-1:0] mq;
   logic [DIV_W-1:0]  mr;

   rsam_div u_div_member (.clock, .advance, .dividend(m1_cq_ff),
                          .divisor(members_of(m1_kind_ff, disks_c, red_count_ff)),
                          .quotient(mq), .remainder(mr));

   logic     back_v_ff [ADDR_W];
   back_type back_ff   [ADDR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ADDR_W; k++) back_v_ff[k] <= 1'b0;
      end else if (advance) begin
         back_v_ff[0] <= m1_v_ff;
         for (int k = 1; k < ADDR_W; k++) back_v_ff[k] <= back_v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         back_ff[0] <= '{kind:       m1_kind_ff,
                         stripe_num: m1_sq_ff,
                         stripe_off: m1_soff_ff,
                         chunk_idx:  m1_cq_ff,
                         chunk_off:  m1_crem_ff[19:0],
                         disk_off:   disk_off_mid,
                         span:       m1_span_ff,
                         err:        m1_err_ff};
         for (int k = 1; k < ADDR_W; k++) back_ff[k] <= back_ff[k-1];
      end
   end

   // Result. The quotient of the modulo divider only checks consistency.
   back_type last;
   assign last = back_ff[ADDR_W-1];

   assign rsp_valid         = back_v_ff[ADDR_W-1];
   assign rsp_stripe_index  = last.stripe_num;
   assign rsp_stripe_offset = last.stripe_off;
   assign rsp_chunk_index   = last.chunk_idx;
   assign rsp_chunk_offset  = last.chunk_off;
   assign rsp_disk_index    = bad_red ? 5'd0 : mr[4:0];
   assign rsp_disk_offset   = last.disk_off;
   assign rsp_stripe_span   = last.span;
   assign rsp_range_error   = last.err;

   `RSAM_ASSERT_IMPL(a_span_nonzero, clock, reset, rsp_valid && !rsp_range_error, rsp_stripe_span != '0, "span is zero on a good range")
   `RSAM_ASSERT_IMPL(a_span_error, clock, reset, rsp_valid && rsp_range_error, rsp_stripe_span == '0, "span is set on an error")
   `RSAM_ASSERT_IMPL(a_disk_range, clock, reset, rsp_valid && !bad_red, DIV_W'(rsp_disk_index) < members_of(last.kind, disks_c, red_count_ff), "disk index beyond members")
   `RSAM_ASSERT_IMPL(a_member_quot, clock, reset, rsp_valid && !bad_red, mq <= last.chunk_idx, "modulo quotient exceeds chunk index")
   `RSAM_ASSERT_IMPL(a_front_rem, clock, reset, front_v_ff[ADDR_W-1], (er < stripe_last) && (pr < pstripe_d), "remainder not below its divisor")
   `RSAM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, req_stall || !req_valid || rsp_valid, "pipeline moved under a stalled result")

endmodule

@@ dv/raid_stripe_address_map_unit_tb.sv @@
// ---------------------------------------------------------------------------
// RAID stripe address map unit testbench
// Drives address translation requests with random bursts and gaps, stalls the
// response channel on its own pattern, and compares every response field with
// a behavioral translation computed from the current register settings.
// ---------------------------------------------------------------------------
module raid_stripe_address_map_unit_tb;
   import rsam_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 98;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic              kind;
   } xlate_req_type;

   typedef struct {
      logic [ADDR_W-1:0] stripe_index;
      logic [24:0]       stripe_offset;
      logic [ADDR_W-1:0] chunk_index;
      logic [19:0]       chunk_offset;
      logic [4:0]        disk_index;
      logic [ADDR_W-1:0] member_offset;
      logic [ADDR_W:0]   stripe_span;
      logic              range_error;
   } xlate_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [DIV_W-1:0]  csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_block_address = '0;
   logic [ADDR_W-1:0] req_end_address = '0;
   logic              req_address_kind = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_stripe_index;
   logic [24:0]       rsp_stripe_offset;
   logic [ADDR_W-1:0] rsp_chunk_index;
   logic [19:0]       rsp_chunk_offset;
   logic [4:0]        rsp_disk_index;
   logic [ADDR_W-1:0] rsp_disk_offset;
   logic [ADDR_W:0]   rsp_stripe_span;
   logic              rsp_range_error;

   // Register shadow, kept at the register widths.
   logic [20:0] chunk_reg;
   logic [5:0]  disks_reg;
   logic [4:0]  redundant_reg;
   logic [25:0] pstripe_reg;
   logic [25:0] lstripe_reg;

   xlate_req_type pending_items[$];
   xlate_rsp_type expected_xlates[$];
   int         mismatches = 0;
   int         unexpected = 0;
   int         accepted = 0;
   int         checked = 0;
   int         errors_seen = 0;
   int         configs_applied = 0;
   longint     cycles = 0;
   bit         sender_hold = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         stall_mode = 0;

   always #5 clock = ~clock;

   raid_stripe_address_map_unit u_top (.*);

   // Behavioral translation of one request under the shadowed registers.
   function automatic xlate_rsp_type translate_address(xlate_req_type r);
      xlate_rsp_type o;
      logic [63:0] chunk, stripe, pstripe, disks, members, chunk_idx, span;
      logic        bad_red, bad_order;
      chunk   = (chunk_reg == 0) ? 64'd1 : 64'(chunk_reg);
      pstripe = (pstripe_reg == 0) ? 64'd1 : 64'(pstripe_reg);
      stripe  = (r.kind == LBA) ? ((lstripe_reg == 0) ? 64'd1 : 64'(lstripe_reg)) : pstripe;
      disks   = (disks_reg > MAX_DISKS) ? 64'(MAX_DISKS) : 64'(disks_reg);
      bad_red   = 64'(redundant_reg) >= disks;
      bad_order = r.end_addr < r.start_addr;
      chunk_idx = 64'(r.start_addr) / chunk;
      o.stripe_index  = ADDR_W'(64'(r.start_addr) / stripe);
      o.stripe_offset = 25'(64'(r.start_addr) % stripe);
      o.chunk_index   = ADDR_W'(chunk_idx);
      o.chunk_offset  = 20'(64'(r.start_addr) % chunk);
      o.disk_index    = '0;
      if (!bad_red) begin
         members = (r.kind == LBA) ? disks - 64'(redundant_reg) : disks;
         o.disk_index = 5'(chunk_idx % members);
      end
      o.member_offset = ADDR_W'((64'(r.start_addr) / pstripe) * chunk
                                + 64'(r.start_addr) % chunk);
      span = 0;
      if (!bad_order && !bad_red)
         span = 64'(r.end_addr) / stripe - 64'(r.start_addr) / stripe + 1;
      o.stripe_span = (ADDR_W+1)'(span);
      o.range_error = bad_order || bad_red;
      return o;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [DIV_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CHUNK_BLOCKS:    chunk_reg = value[20:0];
         CSR_DISK_COUNT:      disks_reg = value[5:0];
         CSR_REDUNDANT_DISKS: redundant_reg = value[4:0];
         CSR_PHYS_STRIPE:     pstripe_reg = value[25:0];
         CSR_LOG_STRIPE:      lstripe_reg = value[25:0];
         default: ;
      endcase
      configs_applied++;
   endtask

   task automatic write_array_geometry(int chunk, int disks, int red);
      write_csr(CSR_CHUNK_BLOCKS, DIV_W'(chunk));
      write_csr(CSR_DISK_COUNT, DIV_W'(disks));
      write_csr(CSR_REDUNDANT_DISKS, DIV_W'(red));
      write_csr(CSR_PHYS_STRIPE, DIV_W'(chunk * disks));
      write_csr(CSR_LOG_STRIPE, DIV_W'(chunk * (disks - red)));
   endtask

   // Waits until the block has drained every item handed to it.
   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_xlates.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] random_address();
      logic [ADDR_W-1:0] a;
      a = ADDR_W'({$urandom, $urandom});
      case ($urandom_range(0, 4))
         0: a = a & ADDR_W'(32'hffff);
         1: a = a & ADDR_W'(32'hffffff);
         2: a = '1 - ADDR_W'($urandom_range(0, 300));
         default: ;
      endcase
      return a;
   endfunction

   task automatic queue_item(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e, logic k);
      xlate_req_type r;
      r.start_addr = s;
      r.end_addr   = e;
      r.kind       = k;
      pending_items.push_back(r);
   endtask

   task automatic queue_random_items(int n);
      logic [ADDR_W-1:0] s, e;
      repeat (n) begin
         s = random_address();
         // Most ranges are well ordered; some run backwards.
         if ($urandom_range(0, 9) < 8) begin
            e = s + ADDR_W'($urandom_range(0, 5000));
            if (e < s) e = '1;
         end else begin
            e = random_address();
         end
         queue_item(s, e, 1'($urandom));
      end
   endtask

   // Driver: the sender works in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_xlates.push_back(translate_address(pending_items.pop_front()));
            accepted++;
         end
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (pending_items.size() != 0 && !sender_hold && gap_left == 0) begin
            req_valid         <= 1'b1;
            req_block_address <= pending_items[0].start_addr;
            req_end_address   <= pending_items[0].end_addr;
            req_address_kind  <= pending_items[0].kind;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // The front of pending_items is on the bus; it is popped on acceptance,
   // so the driver must present it only once. Acceptance is checked above
   // before the next item is read from the queue.

   // Receiver stall pattern and response monitor.
   always @(posedge clock) begin
      xlate_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycles++;
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (expected_xlates.size() == 0) begin
               unexpected++;
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: response with no request outstanding");
            end else begin
               exp_rsp = expected_xlates.pop_front();
               checked++;
               if (exp_rsp.range_error) errors_seen++;
               if (rsp_stripe_index !== exp_rsp.stripe_index
                   || rsp_stripe_offset !== exp_rsp.stripe_offset
                   || rsp_chunk_index !== exp_rsp.chunk_index
                   || rsp_chunk_offset !== exp_rsp.chunk_offset
                   || rsp_disk_index !== exp_rsp.disk_index
                   || rsp_disk_offset !== exp_rsp.member_offset
                   || rsp_stripe_span !== exp_rsp.stripe_span
                   || rsp_range_error !== exp_rsp.range_error) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: response %0d mismatch", checked);
                     $display("  expected si=%h so=%h ci=%h co=%h di=%h do=%h sp=%h er=%b",
                        exp_rsp.stripe_index, exp_rsp.stripe_offset, exp_rsp.chunk_index,
                        exp_rsp.chunk_offset, exp_rsp.disk_index, exp_rsp.member_offset,
                        exp_rsp.stripe_span, exp_rsp.range_error);
                     $display("  actual   si=%h so=%h ci=%h co=%h di=%h do=%h sp=%h er=%b",
                        rsp_stripe_index, rsp_stripe_offset, rsp_chunk_index,
                        rsp_chunk_offset, rsp_disk_index, rsp_disk_offset,
                        rsp_stripe_span, rsp_range_error);
                  end
               end
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      chunk_reg     = 21'd16;
      disks_reg     = 6'd4;
      redundant_reg = 5'd1;
      pstripe_reg   = 26'd64;
      lstripe_reg   = 26'd48;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset geometry: field extremes, both kinds,
      // a backwards range and stripe boundaries.
      queue_item('0, '0, 1'b0);
      queue_item('0, '0, 1'b1);
      queue_item('1, '1, 1'b0);
      queue_item('1, '1, 1'b1);
      queue_item('0, '1, 1'b0);
      queue_item('0, '1, 1'b1);
      queue_item(ADDR_W'(100), ADDR_W'(99), 1'b0);
      queue_item('1, '0, 1'b1);
      queue_item(ADDR_W'(47), ADDR_W'(48), 1'b0);
      queue_item(ADDR_W'(63), ADDR_W'(64), 1'b1);
      queue_item(ADDR_W'(15), ADDR_W'(16), 1'b0);
      queue_item({ADDR_W/2{2'b10}}, {ADDR_W/2{2'b10}}, 1'b1);
      queue_item({ADDR_W/2{2'b01}}, '1, 1'b0);
      wait_drained();

      // Zero sizes act as one; too many disks are clamped to the maximum.
      write_csr(CSR_CHUNK_BLOCKS, '0);
      write_csr(CSR_PHYS_STRIPE, '0);
      write_csr(CSR_LOG_STRIPE, '0);
      write_csr(CSR_DISK_COUNT, DIV_W'(63));
      write_csr(CSR_REDUNDANT_DISKS, DIV_W'(31));
      queue_item(ADDR_W'(12345), ADDR_W'(12400), 1'b0);
      queue_item('1, '1, 1'b1);
      queue_item(ADDR_W'(5), ADDR_W'(4), 1'b1);
      wait_drained();

      // Redundancy not below the disk count flags every item; a clamped disk count follows.
      write_array_geometry(8, 3, 3);
      queue_item(ADDR_W'(1000), ADDR_W'(2000), 1'b0);
      queue_item(ADDR_W'(1000), ADDR_W'(2000), 1'b1);
      wait_drained();
      write_csr(CSR_DISK_COUNT, DIV_W'(40));
      write_csr(CSR_REDUNDANT_DISKS, DIV_W'(31));
      queue_item(ADDR_W'(777), ADDR_W'(9999), 1'b0);
      wait_drained();

      // Random phases over a spread of geometries, extremes among them.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_array_geometry(16, 4, 1);
            1: write_array_geometry(1, 2, 0);
            2: begin
               write_array_geometry(1048576, 32, 31);
               write_csr(CSR_PHYS_STRIPE, DIV_W'(33554432));
               write_csr(CSR_LOG_STRIPE, DIV_W'(33554432));
            end
            3: begin
               write_csr(CSR_CHUNK_BLOCKS, DIV_W'(2097151));
               write_csr(CSR_PHYS_STRIPE, '1);
               write_csr(CSR_LOG_STRIPE, DIV_W'($urandom));
               write_csr(CSR_DISK_COUNT, DIV_W'($urandom_range(2, 63)));
               write_csr(CSR_REDUNDANT_DISKS, DIV_W'($urandom_range(0, 31)));
            end
            default: write_array_geometry($urandom_range(1, 4096),
                                          $urandom_range(2, 32),
                                          $urandom_range(0, 1));
         endcase
         queue_random_items(220);
         // Once, hold the sender until the block has gone quiet.
         if (phase == 4) begin
            while (pending_items.size() > 110) @(posedge clock);
            sender_hold = 1'b1;
            while (expected_xlates.size() != 0) @(posedge clock);
            sender_hold = 1'b0;
         end
         wait_drained();
      end

      $display("Covered %0d translations (%0d flagged as range errors) over %0d register writes.",
               checked, errors_seen, configs_applied);
      if (mismatches == 0 && expected_xlates.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d left outstanding", mismatches, expected_xlates.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ raid_stripe_address_map_unit.f @@
+incdir+rtl
rtl/rsam_pkg.sv
rtl/rsam_div.sv
rtl/raid_stripe_address_map_unit.sv
dv/raid_stripe_address_map_unit_tb.sv
